// File: src/sorted_unique_key_table_defines.svh
// Assertion helpers for the sorted unique key table.
`ifndef SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SUK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SUK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/suk_pkg.sv
package suk_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned CapW  = 7;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic signed [KeyW-1:0] key;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [CntW-1:0]   position;
    logic [CntW-1:0]   count;
    logic              is_full;
    logic              is_empty;
  } result_t;

  // Broadcast to every cell in the update cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// File: src/suk_cell.sv
module suk_cell (
  input  logic                           clk_i,
  input  logic signed [suk_pkg::KeyW-1:0] key_i,
  input  logic signed [suk_pkg::KeyW-1:0] lower_key_i,
  input  logic signed [suk_pkg::KeyW-1:0] upper_key_i,
  input  logic                           prev_lt_i,
  input  logic                           in_use_i,
  input  suk_pkg::cell_ctrl_t            ctrl_i,
  output logic signed [suk_pkg::KeyW-1:0] key_o,
  output logic                           lt_o,
  output logic                           eq_o
);
  import suk_pkg::*;

  logic signed [KeyW-1:0] key_d, key_q;
  logic                   lt_q, eq_q;

  // Insert: keep smaller keys, load at the boundary, take the lower neighbor above it.
  // Remove: keep smaller keys, take the upper neighbor from the hit onward.
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins && !lt_q) begin
      key_d = prev_lt_i ? key_i : lower_key_i;
    end else if (ctrl_i.rem && !lt_q) begin
      key_d = upper_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lt_q  <= in_use_i && (key_q < key_i);
    eq_q  <= in_use_i && (key_q == key_i);
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// File: src/sorted_unique_key_table.sv
// After the accepting edge the table passes through compare and update; the result strobe and
// the result word are registered at the end of the update state.
// Busy is high through compare and update; a new command is accepted only while idle.
// The next start may be accepted in the cycle the result strobe is shown.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset: rst_ni low clears the key count and sets capacity to 64; stored keys are not cleared.
`include "sorted_unique_key_table_defines.svh"

module sorted_unique_key_table (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  suk_pkg::cmd_t          cmd_i,
  output logic                   result_valid_o,
  output suk_pkg::result_t       result_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [suk_pkg::CapW-1:0] cfg_data_i
);
  import suk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_d, state_q;

  logic signed [KeyW-1:0] key_q;
  op_e                    op_q;
  logic [CntW-1:0]        held_d, held_q;
  logic [CapW-1:0]        cap_q;
  logic [CntW-1:0]        cap_eff;

  logic signed [KeyW-1:0] cell_key [Depth];
  logic [Depth-1:0]       lt, eq, in_use, prev_lt;
  cell_ctrl_t             ctrl;

  logic [CntW-1:0]        pos;
  logic                   found, full_now;
  status_e                status;
  result_t                result_q;
  logic                   result_valid_q;

  // Configuration: ready only while idle and no command is starting,
  // so a command never sees the capacity change under it.
  assign cfg_ready_o = !busy && !start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapW'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // Clamp capacity: zero acts as one, anything past the depth as the depth.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (CntW'(cap_q) > CntW'(Depth)) begin
      cap_eff = CntW'(Depth);
    end else begin
      cap_eff = CntW'(cap_q);
    end
  end

  assign busy = (state_q != S_IDLE);

  // Latch the command word at acceptance; hold it through compare and update.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      key_q <= cmd_i.key;
      op_q  <= cmd_i.op;
    end
  end

  // Row of cells. Each cell compares its key to the broadcast key every cycle;
  // its flags are settled in the compare state and used in the update state.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    localparam int unsigned Lo = (i == 0) ? 0 : i - 1;
    localparam int unsigned Hi = (i == Depth - 1) ? Depth - 1 : i + 1;

    assign in_use[i]  = (CntW'(i) < held_q);
    assign prev_lt[i] = (i == 0) ? 1'b1 : lt[Lo];

    suk_cell u_cell (
      .clk_i       (clk_i),
      .key_i       (key_q),
      .lower_key_i (cell_key[Lo]),
      .upper_key_i (cell_key[Hi]),
      .prev_lt_i   (prev_lt[i]),
      .in_use_i    (in_use[i]),
      .ctrl_i      (ctrl),
      .key_o       (cell_key[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i])
    );
  end

  // The less-than flags form a thermometer; encode its edge into the search position.
  always_comb begin
    pos = '0;
    for (int i = 0; i < Depth; i++) begin
      if (!lt[i] && prev_lt[i]) begin
        pos = pos | CntW'(i);
      end
    end
    if (&lt) begin
      pos = CntW'(Depth);
    end
  end

  // Keys are distinct, so any hit among held cells sits at the search position.
  assign found    = |eq;
  assign full_now = (held_q >= cap_eff);

  always_comb begin
    ctrl   = '0;
    status = ST_NOT_FOUND;
    held_d = held_q;
    if (op_q == OP_INSERT) begin
      if (found) begin
        status = ST_DUPLICATE;
      end else if (full_now) begin
        status = ST_FULL;
      end else begin
        status   = ST_INSERTED;
        ctrl.ins = (state_q == S_UPD);
        held_d   = held_q + CntW'(1);
      end
    end else begin
      if (found) begin
        status   = ST_REMOVED;
        ctrl.rem = (state_q == S_UPD);
        held_d   = held_q - CntW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_CMP;
      end
      S_CMP:  state_d = S_UPD;
      S_UPD:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      held_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= (state_q == S_UPD);
      if (state_q == S_UPD) begin
        held_q <= held_d;
      end
    end
  end

  // Result word: registered in the update state and held until the next update; the strobe is shown for one cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      result_q.status   <= status;
      result_q.position <= pos;
      result_q.count    <= held_d;
      result_q.is_full  <= (held_d >= cap_eff);
      result_q.is_empty <= (held_d == '0);
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `SUK_ASSERT_NEXT(a_held_only_in_update, state_q != S_UPD, $stable(held_q),
                   "key count changed outside the update state")
  `SUK_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy,
                   "accepted command did not raise busy")
  `SUK_ASSERT_NEXT(a_update_gives_result, state_q == S_UPD, result_valid_o,
                   "update state did not produce a result strobe")
  `SUK_ASSERT_IMPL(a_count_in_range, result_valid_o, result_o.count <= CntW'(Depth),
                   "result count exceeds the table depth")

endmodule
